/* sv/polar_color_wheel_pixel_core_defines.svh */
// Assertion macros used by the checker file of the color wheel pixel core.
`ifndef POLAR_COLOR_WHEEL_PIXEL_CORE_DEFINES_SVH
`define POLAR_COLOR_WHEEL_PIXEL_CORE_DEFINES_SVH

// Checks that the consequent holds whenever the antecedent holds, outside reset.
`define PCW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition holds at every clock edge outside reset.
`define PCW_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

/* sv/pcw_pkg.sv */
// Shared types, constants and tables of the color wheel pixel core.
`timescale 1ns / 1ps
package pcw_pkg;

    localparam int DIAMETER     = 256;
    localparam int DIV_STEPS    = 32;
    localparam int SQRT_STEPS   = 16;
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_W     = 28;
    localparam int HUE_DELAY    = DIV_STEPS + SQRT_STEPS - (CORDIC_STEPS + 1);
    localparam int COLOR_STAGES = 4;
    localparam int LATENCY      = 3 + DIV_STEPS + SQRT_STEPS + COLOR_STAGES;

    localparam logic [31:0] TURN_QUARTER = 32'h4000_0000;

    localparam logic REG_COLOR_MODE   = 1'b0;
    localparam logic REG_WHEEL_RADIUS = 1'b1;

    typedef enum logic [1:0] {
        MODE_RGB = 2'd0,
        MODE_CMY = 2'd1,
        MODE_HSL = 2'd2,
        MODE_HSV = 2'd3
    } t_color_mode;

    typedef struct packed {
        logic valid;
        logic in_circle;
    } t_ctl;

    localparam logic [31:0] ATAN_TURN [0:CORDIC_STEPS-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

endpackage

/* sv/pcw_saturation.sv */
// Pipelined saturation unit: restoring divider followed by a digit-by-digit square root.
`timescale 1ns / 1ps
module pcw_saturation (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pcw_pkg::t_ctl   i_ctl,
    input  logic [15:0]     i_d2,
    input  logic [15:0]     i_r2,
    output pcw_pkg::t_ctl   o_ctl,
    output logic [15:0]     o_sat
);

    pcw_pkg::t_ctl r_dctl [0:pcw_pkg::DIV_STEPS-1];
    logic [15:0]   r_rem  [0:pcw_pkg::DIV_STEPS-1];
    logic [31:0]   r_quo  [0:pcw_pkg::DIV_STEPS-1];

    pcw_pkg::t_ctl r_sctl [0:pcw_pkg::SQRT_STEPS-1];
    logic [17:0]   r_srem [0:pcw_pkg::SQRT_STEPS-1];
    logic [31:0]   r_sq   [0:pcw_pkg::SQRT_STEPS-1];
    logic [15:0]   r_root [0:pcw_pkg::SQRT_STEPS-1];

    genvar j;
    generate
        for (j = 0; j < pcw_pkg::DIV_STEPS; j++) begin : g_div
            pcw_pkg::t_ctl w_ctl;
            logic [15:0]   w_rem;
            logic [31:0]   w_quo;
            logic [16:0]   w_trial;
            if (j == 0) begin : g_first
                assign w_ctl = i_ctl;
                assign w_rem = i_d2;
                assign w_quo = '0;
            end else begin : g_next
                assign w_ctl = r_dctl[j-1];
                assign w_rem = r_rem[j-1];
                assign w_quo = r_quo[j-1];
            end
            assign w_trial = {w_rem, 1'b0};
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dctl[j] <= '0;
                end else begin
                    r_dctl[j] <= w_ctl;
                end
            end
            always_ff @(posedge i_clk) begin
                if (w_trial >= {1'b0, i_r2}) begin
                    r_rem[j] <= 16'(w_trial - {1'b0, i_r2});
                    r_quo[j] <= {w_quo[30:0], 1'b1};
                end else begin
                    r_rem[j] <= w_trial[15:0];
                    r_quo[j] <= {w_quo[30:0], 1'b0};
                end
            end
        end

        for (j = 0; j < pcw_pkg::SQRT_STEPS; j++) begin : g_sqrt
            pcw_pkg::t_ctl w_ctl;
            logic [17:0]   w_rem;
            logic [31:0]   w_sq;
            logic [15:0]   w_root;
            logic [19:0]   w_shift;
            logic [19:0]   w_test;
            if (j == 0) begin : g_first
                assign w_ctl  = r_dctl[pcw_pkg::DIV_STEPS-1];
                assign w_rem  = '0;
                assign w_sq   = r_quo[pcw_pkg::DIV_STEPS-1];
                assign w_root = '0;
            end else begin : g_next
                assign w_ctl  = r_sctl[j-1];
                assign w_rem  = r_srem[j-1];
                assign w_sq   = r_sq[j-1];
                assign w_root = r_root[j-1];
            end
            assign w_shift = {w_rem, w_sq[31:30]};
            assign w_test  = {2'b00, w_root, 2'b01};
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sctl[j] <= '0;
                end else begin
                    r_sctl[j] <= w_ctl;
                end
            end
            always_ff @(posedge i_clk) begin
                r_sq[j] <= {w_sq[29:0], 2'b00};
                if (w_shift >= w_test) begin
                    r_srem[j] <= 18'(w_shift - w_test);
                    r_root[j] <= {w_root[14:0], 1'b1};
                end else begin
                    r_srem[j] <= w_shift[17:0];
                    r_root[j] <= {w_root[14:0], 1'b0};
                end
            end
        end
    endgenerate

    assign o_ctl = r_sctl[pcw_pkg::SQRT_STEPS-1];
    assign o_sat = r_root[pcw_pkg::SQRT_STEPS-1];

endmodule

/* sv/pcw_cordic.sv */
// Pipelined CORDIC in vectoring mode that turns the offset vector into a hue fraction.
`timescale 1ns / 1ps
module pcw_cordic (
    input  logic              i_clk,
    input  logic signed [8:0] i_dx,
    input  logic signed [8:0] i_dy,
    output logic [15:0]       o_hue
);

    logic signed [pcw_pkg::CORDIC_W-1:0] r_x    [0:pcw_pkg::CORDIC_STEPS];
    logic signed [pcw_pkg::CORDIC_W-1:0] r_y    [0:pcw_pkg::CORDIC_STEPS];
    logic [31:0]                         r_acc  [0:pcw_pkg::CORDIC_STEPS];
    logic                                r_zero [0:pcw_pkg::CORDIC_STEPS];

    logic signed [pcw_pkg::CORDIC_W-1:0] w_x0;
    logic signed [pcw_pkg::CORDIC_W-1:0] w_y0;
    logic w_xpos;
    logic w_xneg;
    logic w_ypos;
    logic w_yneg;

    assign w_x0   = {{(pcw_pkg::CORDIC_W - 25){i_dx[8]}}, i_dx, 16'h0000};
    assign w_y0   = {{(pcw_pkg::CORDIC_W - 25){i_dy[8]}}, i_dy, 16'h0000};
    assign w_xneg = i_dx[8];
    assign w_yneg = i_dy[8];
    assign w_xpos = !i_dx[8] && (i_dx != 9'sd0);
    assign w_ypos = !i_dy[8] && (i_dy != 9'sd0);

    // The vector is first turned by whole quarter turns into the first quadrant.
    always_ff @(posedge i_clk) begin
        r_zero[0] <= (i_dx == 9'sd0) && (i_dy == 9'sd0);
        if (w_xpos && !w_yneg) begin
            r_x[0]   <= w_x0;
            r_y[0]   <= w_y0;
            r_acc[0] <= '0;
        end else if (!w_xpos && w_ypos) begin
            r_x[0]   <= w_y0;
            r_y[0]   <= -w_x0;
            r_acc[0] <= pcw_pkg::TURN_QUARTER;
        end else if (w_xneg && !w_ypos) begin
            r_x[0]   <= -w_x0;
            r_y[0]   <= -w_y0;
            r_acc[0] <= 32'(pcw_pkg::TURN_QUARTER * 2);
        end else begin
            r_x[0]   <= -w_y0;
            r_y[0]   <= w_x0;
            r_acc[0] <= 32'(pcw_pkg::TURN_QUARTER * 3);
        end
    end

    genvar i;
    generate
        for (i = 0; i < pcw_pkg::CORDIC_STEPS; i++) begin : g_step
            logic signed [pcw_pkg::CORDIC_W-1:0] w_xs;
            logic signed [pcw_pkg::CORDIC_W-1:0] w_ys;
            logic w_pos;
            logic w_neg;
            assign w_xs  = r_x[i] >>> i;
            assign w_ys  = r_y[i] >>> i;
            assign w_neg = r_y[i][pcw_pkg::CORDIC_W-1];
            assign w_pos = !w_neg && (r_y[i] != '0);
            always_ff @(posedge i_clk) begin
                r_zero[i+1] <= r_zero[i];
                if (w_pos) begin
                    r_x[i+1]   <= r_x[i] + w_ys;
                    r_y[i+1]   <= r_y[i] - w_xs;
                    r_acc[i+1] <= r_acc[i] + pcw_pkg::ATAN_TURN[i];
                end else if (w_neg) begin
                    r_x[i+1]   <= r_x[i] - w_ys;
                    r_y[i+1]   <= r_y[i] + w_xs;
                    r_acc[i+1] <= r_acc[i] - pcw_pkg::ATAN_TURN[i];
                end else begin
                    r_x[i+1]   <= r_x[i];
                    r_y[i+1]   <= r_y[i];
                    r_acc[i+1] <= r_acc[i];
                end
            end
        end
    endgenerate

    assign o_hue = r_zero[pcw_pkg::CORDIC_STEPS] ? 16'h0000
                                                 : r_acc[pcw_pkg::CORDIC_STEPS][31:16];

endmodule

/* sv/pcw_color.sv */
// Four-stage color mapper from saturation and hue to RGBA bytes for all four modes.
`timescale 1ns / 1ps
module pcw_color (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pcw_pkg::t_color_mode i_mode,
    input  pcw_pkg::t_ctl        i_ctl,
    input  logic [15:0]          i_sat,
    input  logic [15:0]          i_hue,
    output logic                 o_valid,
    output logic [7:0]           o_red,
    output logic [7:0]           o_green,
    output logic [7:0]           o_blue,
    output logic [7:0]           o_alpha
);

    localparam logic [16:0] ONE16 = 17'h10000;
    localparam logic [32:0] ONE32 = 33'h1_0000_0000;
    localparam logic [32:0] HALF32 = 33'h0_8000_0000;

    function automatic logic [7:0] to_byte(input logic [32:0] v);
        logic [40:0] w_p;
        w_p = {v, 8'h00} - {8'h00, v};
        return w_p[39:32];
    endfunction

    pcw_pkg::t_ctl r0_ctl, r1_ctl, r2_ctl, r3_ctl;
    logic [15:0] r0_sat, r0_hue, r0_f;
    logic [16:0] r0_dist;
    logic [2:0]  r0_sector;
    logic [15:0] r1_sat, r1_hue;
    logic [2:0]  r1_sector;
    logic [31:0] r1_sf, r1_sg, r1_sx;
    logic [32:0] r2_r, r2_g, r2_b;
    logic [7:0]  r3_red, r3_green, r3_blue, r3_alpha;

    logic [18:0] w_h6;
    logic [16:0] w_m;
    logic [32:0] n_r, n_g, n_b;
    logic [32:0] w_a, w_c, w_x, w_z, w_light;

    assign w_h6 = 19'({3'b000, i_hue} << 2) + 19'({3'b000, i_hue} << 1);
    assign w_m  = w_h6[16:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_ctl <= '0;
            r1_ctl <= '0;
            r2_ctl <= '0;
            r3_ctl <= '0;
        end else begin
            r0_ctl <= i_ctl;
            r1_ctl <= r0_ctl;
            r2_ctl <= r1_ctl;
            r3_ctl <= r2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_sat    <= i_sat;
        r0_hue    <= i_hue;
        r0_sector <= w_h6[18:16];
        r0_f      <= w_h6[15:0];
        r0_dist   <= (w_m >= ONE16) ? (w_m - ONE16) : (ONE16 - w_m);

        r1_sat    <= r0_sat;
        r1_hue    <= r0_hue;
        r1_sector <= r0_sector;
        r1_sf     <= {16'h0000, r0_sat} * {16'h0000, r0_f};
        r1_sg     <= {16'h0000, r0_sat} * {15'h0000, ONE16 - {1'b0, r0_f}};
        r1_sx     <= {16'h0000, r0_sat} * {15'h0000, ONE16 - r0_dist};

        r2_r <= n_r;
        r2_g <= n_g;
        r2_b <= n_b;

        r3_red   <= to_byte(r2_r);
        r3_green <= to_byte(r2_g);
        r3_blue  <= to_byte(r2_b);
        r3_alpha <= r2_ctl.in_circle ? 8'hFF : 8'h00;
    end

    always_comb begin
        w_a     = ONE32;
        w_c     = ONE32 - {1'b0, r1_sf};
        w_x     = ONE32 - {1'b0, r1_sg};
        w_z     = {ONE16 - {1'b0, r1_sat}, 16'h0000};
        w_light = HALF32 - {2'b00, r1_sat, 15'h0000};
        n_r = '0;
        n_g = '0;
        n_b = '0;
        case (i_mode)
            pcw_pkg::MODE_RGB: begin
                n_r = {1'b0, r1_sat, 16'h0000};
                n_g = {1'b0, r1_hue, 16'h0000};
            end
            pcw_pkg::MODE_CMY: begin
                n_r = {ONE16 - {1'b0, r1_sat}, 16'h0000};
                n_g = {ONE16 - {1'b0, r1_hue}, 16'h0000};
            end
            pcw_pkg::MODE_HSV: begin
                case (r1_sector)
                    3'd0: begin n_r = w_a; n_g = w_x; n_b = w_z; end
                    3'd1: begin n_r = w_c; n_g = w_a; n_b = w_z; end
                    3'd2: begin n_r = w_z; n_g = w_a; n_b = w_x; end
                    3'd3: begin n_r = w_z; n_g = w_c; n_b = w_a; end
                    3'd4: begin n_r = w_x; n_g = w_z; n_b = w_a; end
                    default: begin n_r = w_a; n_g = w_z; n_b = w_c; end
                endcase
            end
            default: begin
                w_c = {1'b0, r1_sat, 16'h0000} + w_light;
                w_x = {1'b0, r1_sx} + w_light;
                w_z = w_light;
                case (r1_sector)
                    3'd0: begin n_r = w_c; n_g = w_x; n_b = w_z; end
                    3'd1: begin n_r = w_x; n_g = w_c; n_b = w_z; end
                    3'd2: begin n_r = w_z; n_g = w_c; n_b = w_x; end
                    3'd3: begin n_r = w_z; n_g = w_x; n_b = w_c; end
                    3'd4: begin n_r = w_x; n_g = w_z; n_b = w_c; end
                    default: begin n_r = w_c; n_g = w_z; n_b = w_x; end
                endcase
            end
        endcase
        if (!r1_ctl.in_circle) begin
            n_r = '0;
            n_g = '0;
            n_b = '0;
        end
    end

    assign o_valid = r3_ctl.valid;
    assign o_red   = r3_red;
    assign o_green = r3_green;
    assign o_blue  = r3_blue;
    assign o_alpha = r3_alpha;

endmodule

/* sv/polar_color_wheel_pixel_core.sv */
// Top level of the color wheel pixel core: geometry front end, hue and saturation, color.
// o_done is registered through the front-end stages, the divider, the root and the color stages.
// Throughput is one item per cycle; the 32-step divider and 16-step root set the depth.
// o_busy is always low and results cannot be held off by the receiver.
// Synchronous active-low reset clears all valid bits and sets mode HSV and radius 128.
`timescale 1ns / 1ps
module polar_color_wheel_pixel_core #(
    parameter int DIAMETER = pcw_pkg::DIAMETER
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  logic [7:0] i_pixel_x,
    input  logic [7:0] i_pixel_y,
    input  logic       i_cfg_we,
    input  logic       i_cfg_addr,
    input  logic [7:0] i_cfg_wdata,
    output logic       o_done,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue,
    output logic [7:0] o_alpha
);

    localparam logic [10:0] DIAMETER_LIM = 11'(DIAMETER);

    pcw_pkg::t_color_mode r_mode;
    logic [7:0]  r_radius;
    logic [15:0] r_r2;

    logic        r_s1_vld;
    logic [7:0]  r_s1_x, r_s1_y;
    logic        r_s2_vld;
    logic        r_s2_oob;
    logic signed [8:0] r_s2_dx, r_s2_dy;
    logic [15:0] r_s2_dx2, r_s2_dy2;
    pcw_pkg::t_ctl r_s3_ctl;
    logic [15:0] r_s3_d2;
    logic signed [8:0] r_s3_dx, r_s3_dy;

    logic signed [8:0]  w_dx, w_dy;
    logic signed [17:0] w_dx2, w_dy2;
    logic [16:0] w_d2;
    logic        w_in_circle;

    logic [15:0] r_hue_dly [0:pcw_pkg::HUE_DELAY-1];
    logic [15:0] w_hue;
    pcw_pkg::t_ctl w_sat_ctl;
    logic [15:0] w_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= pcw_pkg::MODE_HSV;
            r_radius <= 8'd128;
            r_r2     <= 16'd16384;
        end else begin
            r_r2 <= {8'h00, r_radius} * {8'h00, r_radius};
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    pcw_pkg::REG_COLOR_MODE:   r_mode <= pcw_pkg::t_color_mode'(i_cfg_wdata[1:0]);
                    pcw_pkg::REG_WHEEL_RADIUS: r_radius <= i_cfg_wdata;
                    default: r_radius <= r_radius;
                endcase
            end
        end
    end

    assign w_dx  = 9'({1'b0, r_s1_x}) - 9'({1'b0, r_radius});
    assign w_dy  = 9'({1'b0, r_radius}) - 9'({1'b0, r_s1_y});
    assign w_dx2 = w_dx * w_dx;
    assign w_dy2 = w_dy * w_dy;
    assign w_d2  = {1'b0, r_s2_dx2} + {1'b0, r_s2_dy2};
    assign w_in_circle = !r_s2_oob && (w_d2 < {1'b0, r_r2});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_ctl <= '0;
        end else begin
            r_s1_vld <= i_start && !o_busy;
            r_s2_vld <= r_s1_vld;
            r_s3_ctl <= '{valid: r_s2_vld, in_circle: w_in_circle};
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_x   <= i_pixel_x;
        r_s1_y   <= i_pixel_y;
        r_s2_dx  <= w_dx;
        r_s2_dy  <= w_dy;
        r_s2_dx2 <= w_dx2[15:0];
        r_s2_dy2 <= w_dy2[15:0];
        r_s2_oob <= ({3'b000, r_s1_x} >= DIAMETER_LIM)
                 || ({3'b000, r_s1_y} >= DIAMETER_LIM);
        r_s3_d2  <= w_in_circle ? w_d2[15:0] : 16'h0000;
        r_s3_dx  <= r_s2_dx;
        r_s3_dy  <= r_s2_dy;
    end

    pcw_saturation u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_s3_ctl),
        .i_d2    (r_s3_d2),
        .i_r2    (r_r2),
        .o_ctl   (w_sat_ctl),
        .o_sat   (w_sat)
    );

    pcw_cordic u_cordic (
        .i_clk (i_clk),
        .i_dx  (r_s3_dx),
        .i_dy  (r_s3_dy),
        .o_hue (w_hue)
    );

    always_ff @(posedge i_clk) begin
        r_hue_dly[0] <= w_hue;
        for (int k = 1; k < pcw_pkg::HUE_DELAY; k++) begin
            r_hue_dly[k] <= r_hue_dly[k-1];
        end
    end

    pcw_color u_color (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_mode),
        .i_ctl   (w_sat_ctl),
        .i_sat   (w_sat),
        .i_hue   (r_hue_dly[pcw_pkg::HUE_DELAY-1]),
        .o_valid (o_done),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue),
        .o_alpha (o_alpha)
    );

    assign o_busy = 1'b0;

endmodule

/* sv/pcw_checker.sv */
// Port-level checker of the color wheel pixel core and its bind to the top level.
`timescale 1ns / 1ps
`include "polar_color_wheel_pixel_core_defines.svh"
module pcw_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       o_busy,
    input logic       o_done,
    input logic [7:0] o_red,
    input logic [7:0] o_green,
    input logic [7:0] o_blue,
    input logic [7:0] o_alpha
);

    logic r_start_dly [0:pcw_pkg::LATENCY-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < pcw_pkg::LATENCY; k++) begin
                r_start_dly[k] <= 1'b0;
            end
        end else begin
            r_start_dly[0] <= i_start && !o_busy;
            for (int k = 1; k < pcw_pkg::LATENCY; k++) begin
                r_start_dly[k] <= r_start_dly[k-1];
            end
        end
    end

    `PCW_ASSERT_ALWAYS(a_never_busy, i_clk, i_rst_n, !o_busy, "busy raised")
    `PCW_ASSERT_IMPL(a_done_has_item, i_clk, i_rst_n, o_done, r_start_dly[pcw_pkg::LATENCY-1], "result without item")
    `PCW_ASSERT_IMPL(a_alpha_code, i_clk, i_rst_n, o_done, (o_alpha == 8'hFF) || (o_alpha == 8'h00), "bad alpha")
    `PCW_ASSERT_IMPL(a_outside_black, i_clk, i_rst_n, o_done && (o_alpha == 8'h00), (o_red | o_green | o_blue) == 8'h00, "outside not black")

endmodule

bind polar_color_wheel_pixel_core pcw_checker u_pcw_checker (.*);

/* bench/polar_color_wheel_pixel_core_tb.sv */
// Self-checking testbench for the color wheel pixel core with a built-in color predictor.
`timescale 1ns / 1ps
module polar_color_wheel_pixel_core_tb;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_rgba;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_start;
    logic       o_busy;
    logic [7:0] i_pixel_x;
    logic [7:0] i_pixel_y;
    logic       i_cfg_we;
    logic       i_cfg_addr;
    logic [7:0] i_cfg_wdata;
    logic       o_done;
    logic [7:0] o_red;
    logic [7:0] o_green;
    logic [7:0] o_blue;
    logic [7:0] o_alpha;

    pcw_pkg::t_color_mode cur_mode;
    logic [7:0]   cur_radius;
    t_rgba        pending_colors[$];
    int           error_count;
    int           pixel_count;
    int           result_count;

    localparam logic [31:0] ATAN_STEP [0:23] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    polar_color_wheel_pixel_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_pixel_x   (i_pixel_x),
        .i_pixel_y   (i_pixel_y),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (o_done),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue),
        .o_alpha     (o_alpha)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [15:0] hue_turn(longint dx, longint dy);
        longint x;
        longint y;
        longint t;
        longint nx;
        longint ny;
        logic [31:0] acc;
        bit stop;
        x = dx * 65536;
        y = dy * 65536;
        acc = 0;
        stop = 0;
        if (dx == 0 && dy == 0) return 16'd0;
        for (int k = 0; k < 3 && !(x > 0 && y >= 0); k++) begin
            t = x;
            x = y;
            y = -t;
            acc = acc + pcw_pkg::TURN_QUARTER;
        end
        for (int i = 0; i < 24; i++) begin
            if (!stop) begin
                if (y > 0) begin
                    nx = x + (y >>> i);
                    ny = y - (x >>> i);
                    acc = acc + ATAN_STEP[i];
                    x = nx;
                    y = ny;
                end else if (y < 0) begin
                    nx = x - (y >>> i);
                    ny = y + (x >>> i);
                    acc = acc - ATAN_STEP[i];
                    x = nx;
                    y = ny;
                end else begin
                    stop = 1;
                end
            end
        end
        return acc[31:16];
    endfunction

    function automatic logic [7:0] byte_of(logic [63:0] v32);
        logic [63:0] p;
        p = (64'd255 * v32) >> 32;
        return p[7:0];
    endfunction

    function automatic t_rgba predict_color(logic [7:0] px, logic [7:0] py);
        longint rad;
        longint dx;
        longint dy;
        logic [63:0] d2, r2, s16, h16, h6, sector, f, r, g, b;
        logic [63:0] full, p, q, tt, m, tri_dist, light, c, x0;
        t_rgba res;
        rad = cur_radius;
        dx = longint'(px) - rad;
        dy = rad - longint'(py);
        d2 = dx * dx + dy * dy;
        r2 = rad * rad;
        res = '0;
        if (d2 >= r2) return res;
        s16 = int_sqrt((d2 << 32) / r2);
        h16 = hue_turn(dx, dy);
        r = 0;
        g = 0;
        b = 0;
        if (cur_mode == pcw_pkg::MODE_RGB) begin
            r = (64'd255 * s16) >> 16;
            g = (64'd255 * h16) >> 16;
        end else if (cur_mode == pcw_pkg::MODE_CMY) begin
            r = (64'd255 * (64'd65536 - s16)) >> 16;
            g = (64'd255 * (64'd65536 - h16)) >> 16;
        end else begin
            h6 = 6 * h16;
            sector = h6 >> 16;
            f = h6 & 64'hFFFF;
            if (cur_mode == pcw_pkg::MODE_HSV) begin
                full = 64'd1 << 32;
                p = (64'd65536 - s16) << 16;
                q = full - s16 * f;
                tt = full - s16 * (64'd65536 - f);
                case (sector)
                    0: begin r = full; g = tt; b = p; end
                    1: begin r = q; g = full; b = p; end
                    2: begin r = p; g = full; b = tt; end
                    3: begin r = p; g = q; b = full; end
                    4: begin r = tt; g = p; b = full; end
                    default: begin r = full; g = p; b = q; end
                endcase
            end else begin
                m = h6 & 64'h1FFFF;
                tri_dist = (m >= 64'd65536) ? (m - 64'd65536) : (64'd65536 - m);
                light = (64'd1 << 31) - (s16 << 15);
                c = s16 << 16;
                x0 = s16 * (64'd65536 - tri_dist);
                case (sector)
                    0: begin r = c; g = x0; b = 0; end
                    1: begin r = x0; g = c; b = 0; end
                    2: begin r = 0; g = c; b = x0; end
                    3: begin r = 0; g = x0; b = c; end
                    4: begin r = x0; g = 0; b = c; end
                    default: begin r = c; g = 0; b = x0; end
                endcase
                r = r + light;
                g = g + light;
                b = b + light;
            end
            r = byte_of(r);
            g = byte_of(g);
            b = byte_of(b);
        end
        res.red = r[7:0];
        res.green = g[7:0];
        res.blue = b[7:0];
        res.alpha = 8'd255;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        $display("%0t: %s mismatch, got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_rgba want;
        if (i_rst_n && o_done) begin
            result_count++;
            if (pending_colors.size() == 0) begin
                $display("%0t: result with no pixel pending", $realtime);
                error_count++;
            end else begin
                want = pending_colors.pop_front();
                if (o_red !== want.red) report_mismatch("red", o_red, want.red);
                if (o_green !== want.green) report_mismatch("green", o_green, want.green);
                if (o_blue !== want.blue) report_mismatch("blue", o_blue, want.blue);
                if (o_alpha !== want.alpha) report_mismatch("alpha", o_alpha, want.alpha);
            end
        end
    end

    task automatic send_pixel(logic [7:0] px, logic [7:0] py);
        @(negedge i_clk);
        i_start <= 1'b1;
        i_pixel_x <= px;
        i_pixel_y <= py;
        while (o_busy) @(negedge i_clk);
        @(posedge i_clk);
        pending_colors.push_back(predict_color(px, py));
        pixel_count++;
    endtask

    task automatic idle_cycles(int n);
        repeat (n) begin
            @(negedge i_clk);
            i_start <= 1'b0;
        end
    endtask

    task automatic random_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55) return;
        else if (sel < 92) idle_cycles($urandom_range(1, 3));
        else idle_cycles($urandom_range(10, 60));
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending_colors.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic addr, logic [7:0] data);
        drain_results();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (addr == pcw_pkg::REG_COLOR_MODE) cur_mode = pcw_pkg::t_color_mode'(data[1:0]);
        else cur_radius = data;
    endtask

    task automatic test_modes_at_reset_radius();
        for (int md = 0; md < 4; md++) begin
            write_reg(pcw_pkg::REG_COLOR_MODE, 8'(md));
            send_pixel(8'd128, 8'd128);
            send_pixel(8'd0, 8'd0);
            send_pixel(8'd200, 8'd60);
            send_pixel(8'd30, 8'd150);
        end
    endtask

    task automatic test_radius_extremes();
        write_reg(pcw_pkg::REG_WHEEL_RADIUS, 8'd0);
        send_pixel(8'd0, 8'd0);
        send_pixel(8'd255, 8'd255);
        write_reg(pcw_pkg::REG_WHEEL_RADIUS, 8'd1);
        send_pixel(8'd1, 8'd1);
        send_pixel(8'd0, 8'd1);
        write_reg(pcw_pkg::REG_WHEEL_RADIUS, 8'd255);
        send_pixel(8'd255, 8'd255);
        send_pixel(8'd128, 8'd255);
        send_pixel(8'd255, 8'd0);
    endtask

    task automatic test_random_phases();
        int span;
        bit steady;
        logic [7:0] px;
        logic [7:0] py;
        for (int ph = 0; ph < 12; ph++) begin
            write_reg(pcw_pkg::REG_COLOR_MODE, 8'($urandom_range(0, 3)));
            case ($urandom_range(0, 7))
                0: write_reg(pcw_pkg::REG_WHEEL_RADIUS, 8'd1);
                1: write_reg(pcw_pkg::REG_WHEEL_RADIUS, 8'd128);
                2: write_reg(pcw_pkg::REG_WHEEL_RADIUS, 8'd255);
                3: write_reg(pcw_pkg::REG_WHEEL_RADIUS, 8'($urandom_range(129, 254)));
                default: write_reg(pcw_pkg::REG_WHEEL_RADIUS, 8'($urandom_range(2, 128)));
            endcase
            span = (2 * cur_radius > 255) ? 255 : 2 * cur_radius;
            steady = ($urandom_range(0, 3) == 0);
            repeat (42) begin
                if ($urandom_range(0, 9) < 8) begin
                    px = 8'($urandom_range(0, span));
                    py = 8'($urandom_range(0, span));
                end else begin
                    px = 8'($urandom);
                    py = 8'($urandom);
                end
                send_pixel(px, py);
                if (!steady) random_gap();
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_pixel_x = '0;
        i_pixel_y = '0;
        i_cfg_we = 1'b0;
        i_cfg_addr = pcw_pkg::REG_COLOR_MODE;
        i_cfg_wdata = '0;
        cur_mode = pcw_pkg::MODE_HSV;
        cur_radius = 8'd128;
        error_count = 0;
        pixel_count = 0;
        result_count = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_pixel(8'd100, 8'd20);
        test_modes_at_reset_radius();
        test_radius_extremes();
        test_random_phases();
        drain_results();
        repeat (pcw_pkg::LATENCY + 10) @(posedge i_clk);
        $display("Sent %0d pixels in all four modes, radius 0 through 255; checked %0d results.",
                 pixel_count, result_count);
        if (error_count == 0) begin
            $display("polar_color_wheel_pixel_core_tb: done, clean");
        end else begin
            $display("polar_color_wheel_pixel_core_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d results pending.", pending_colors.size());
        $display("polar_color_wheel_pixel_core_tb: done, errors");
        $finish;
    end

endmodule

/* polar_color_wheel_pixel_core.f */
+incdir+sv
sv/pcw_pkg.sv
sv/pcw_saturation.sv
sv/pcw_cordic.sv
sv/pcw_color.sv
sv/polar_color_wheel_pixel_core.sv
sv/pcw_checker.sv
bench/polar_color_wheel_pixel_core_tb.sv
